// ----- src/ric_pkg.sv -----
// Shared types and constants for the relay interlock and inching control block.
package ric_pkg;

	localparam int CH_W      = 2;   // width of a reported channel number
	localparam int TICK_W    = 31;  // width of an inching count
	localparam int INCH_N    = 4;   // inching registers held, one per possible channel
	localparam int CFG_IDX_W = 3;   // width of the configuration register index

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_INTERLOCK = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_INCH_CH0  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_INCH_CH3  = 3'd4;

	// one report: channel and the state now applied to it
	typedef struct packed {
		logic [CH_W-1:0] ch;
		logic            on;
	} ric_res_t;

	// sequencer to output stage
	typedef struct packed {
		logic push;   // a new report is ready
		logic flush;  // the item is done; release the held report as the final one
	} ric_ctl_t;

	// output stage to sequencer
	typedef struct packed {
		logic room;   // a push or flush is taken in this cycle
	} ric_sts_t;

endpackage

// ----- src/ric_tick_unit.sv -----
// Shared countdown unit: decrements one channel count and flags its expiry.
module ric_tick_unit (
	input  logic [ric_pkg::TICK_W-1:0] value,
	output logic [ric_pkg::TICK_W-1:0] dec,
	output logic                       pending,
	output logic                       expire
);
	import ric_pkg::*;

	assign pending = (value != '0);
	assign dec     = value - TICK_W'(1);
	assign expire  = pending && (dec == '0);

endmodule

// ----- src/ric_out_stage.sv -----
// Report holding stage and output register; marks the final report of each item.
module ric_out_stage (
	input  logic              clk,
	input  logic              arst_n,
	input  ric_pkg::ric_ctl_t ctl,
	input  ric_pkg::ric_res_t res,
	output ric_pkg::ric_sts_t sts,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [ric_pkg::CH_W-1:0] changed_channel,
	output logic              new_state,
	output logic              last
);
	import ric_pkg::*;

	ric_res_t pend_q;
	logic     pend_v_q;
	ric_res_t out_q;
	logic     out_last_q;
	logic     out_v_q;
	logic     out_free;
	logic     take_push;
	logic     load_out;

	assign out_free  = !out_v_q || out_ready;
	assign sts.room  = !pend_v_q || out_free;
	assign take_push = ctl.push && sts.room;
	// a held report moves out when a newer one arrives or the item ends
	assign load_out  = pend_v_q && out_free && (ctl.push || ctl.flush);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_v_q <= 1'b0;
			out_v_q  <= 1'b0;
		end else begin
			if (take_push) begin
				pend_v_q <= 1'b1;
			end else if (ctl.flush && load_out) begin
				pend_v_q <= 1'b0;
			end
			if (load_out) begin
				out_v_q <= 1'b1;
			end else if (out_v_q && out_ready) begin
				out_v_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take_push) begin
			pend_q <= res;
		end
		if (load_out) begin
			out_q      <= pend_q;
			out_last_q <= !ctl.push;
		end
	end

	assign out_valid       = out_v_q;
	assign changed_channel = out_q.ch;
	assign new_state       = out_q.on;
	assign last            = out_last_q;

endmodule

// ----- src/relay_interlock_inching_control_core.sv -----
// Top level: relay interlock with per-channel inching countdown, channel-serial sequencer.
//
// Input channel (in_valid/in_ready, mode, channel, turn_on): mode 0 is a command that
// sets one relay, mode 1 is a timer tick. in_ready is high only while the block is idle.
// Output channel (out_valid/out_ready, changed_channel, new_state, last): one item per
// relay change and per applied command; last marks the final report of an input item.
// Items with no report (an out-of-range channel, a tick with no expiring count) produce
// nothing. The sequencer visits one channel per cycle through a single countdown unit
// while the output stage has room: a command is accepted, every channel is scanned, the
// command is applied and the item is flushed; a tick is accepted, scanned and flushed;
// an out-of-range command is accepted and dropped while the block stays idle.
// Reports are held one deep so the last flag can be set; a report reaches the output
// register when the next one is produced, the final one in the flush cycle.
// A stalled receiver stalls the scan once both the held report and the output register
// are full; nothing is dropped. Configuration writes (cfg_wr_en, cfg_index, cfg_data)
// take effect at once and are meant to be issued while the block is idle.
// Reset (arst_n low) turns all relays off, clears every countdown, the interlock enable
// and the inching registers, and empties the output.
module relay_interlock_inching_control_core #(
	parameter int CHANNELS = 4
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_wr_en,
	input  logic [ric_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [ric_pkg::TICK_W-1:0]    cfg_data,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic                          mode,
	input  logic [2:0]                    channel,
	input  logic                          turn_on,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [ric_pkg::CH_W-1:0]      changed_channel,
	output logic                          new_state,
	output logic                          last
);
	import ric_pkg::*;

	localparam int IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
	localparam logic [2:0]       CH_LIM   = 3'(CHANNELS);
	localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(CHANNELS - 1);

	localparam logic [1:0] S_IDLE  = 2'd0;
	localparam logic [1:0] S_SCAN  = 2'd1;
	localparam logic [1:0] S_CMD   = 2'd2;
	localparam logic [1:0] S_FLUSH = 2'd3;

	logic [1:0]          state_q;
	logic [IDX_W-1:0]    cnt_q;
	logic [IDX_W-1:0]    ch_q;
	logic                mode_q;
	logic                on_q;
	logic                il_q;
	logic [TICK_W-1:0]   inch_q [INCH_N];
	logic [TICK_W-1:0]   rem_q  [CHANNELS];
	logic [CHANNELS-1:0] relay_q;

	logic [TICK_W-1:0]   tu_dec;
	logic                tu_pending;
	logic                tu_expire;
	logic [TICK_W-1:0]   inch_sel;
	logic                accept;
	logic                in_range;
	logic                hit_tick;
	logic                hit_il;
	logic                step;
	ric_ctl_t            ctl;
	ric_sts_t            sts;
	ric_res_t            res;

	ric_tick_unit u_tick (
		.value   (rem_q[cnt_q]),
		.dec     (tu_dec),
		.pending (tu_pending),
		.expire  (tu_expire)
	);

	assign in_ready = (state_q == S_IDLE);
	assign accept   = in_valid && in_ready;
	assign in_range = (channel < CH_LIM);
	assign inch_sel = inch_q[CH_W'(ch_q)];
	assign step     = sts.room;

	assign hit_tick = mode_q && tu_expire;
	assign hit_il   = !mode_q && on_q && il_q && (cnt_q != ch_q) && relay_q[cnt_q];

	always_comb begin
		ctl.push  = 1'b0;
		ctl.flush = (state_q == S_FLUSH);
		res.ch    = CH_W'(cnt_q);
		res.on    = 1'b0;
		case (state_q)
			S_SCAN: begin
				ctl.push = hit_tick || hit_il;
			end
			S_CMD: begin
				ctl.push = 1'b1;
				res.ch   = CH_W'(ch_q);
				res.on   = on_q;
			end
			default: begin
				ctl.push = 1'b0;
			end
		endcase
	end

	ric_out_stage u_out (
		.clk             (clk),
		.arst_n          (arst_n),
		.ctl             (ctl),
		.res             (res),
		.sts             (sts),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.changed_channel (changed_channel),
		.new_state       (new_state),
		.last            (last)
	);

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			il_q <= 1'b0;
			for (int i = 0; i < INCH_N; i++) begin
				inch_q[i] <= '0;
			end
		end else if (cfg_wr_en) begin
			if (cfg_index == REG_INTERLOCK) begin
				il_q <= cfg_data[0];
			end else if (cfg_index >= REG_INCH_CH0 && cfg_index <= REG_INCH_CH3) begin
				inch_q[CH_W'(cfg_index - REG_INCH_CH0)] <= cfg_data;
			end
		end
	end

	// sequencer and relay state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q   <= '0;
			ch_q    <= '0;
			mode_q  <= 1'b0;
			on_q    <= 1'b0;
			relay_q <= '0;
			for (int i = 0; i < CHANNELS; i++) begin
				rem_q[i] <= '0;
			end
		end else begin
			case (state_q)
				S_IDLE: begin
					if (accept && (mode || in_range)) begin
						state_q <= S_SCAN;
						cnt_q   <= '0;
						ch_q    <= channel[IDX_W-1:0];
						mode_q  <= mode;
						on_q    <= turn_on;
					end
				end
				S_SCAN: begin
					if (step) begin
						if (mode_q) begin
							if (tu_pending) begin
								rem_q[cnt_q] <= tu_dec;
							end
						end else if (hit_il) begin
							rem_q[cnt_q] <= '0;
						end
						if (hit_tick || hit_il) begin
							relay_q[cnt_q] <= 1'b0;
						end
						if (cnt_q == IDX_LAST) begin
							cnt_q   <= '0;
							state_q <= mode_q ? S_FLUSH : S_CMD;
						end else begin
							cnt_q <= cnt_q + IDX_W'(1);
						end
					end
				end
				S_CMD: begin
					if (step) begin
						// apply the commanded channel; a turn-on restarts its countdown
						relay_q[ch_q] <= on_q;
						rem_q[ch_q]   <= on_q ? inch_sel : '0;
						state_q       <= S_FLUSH;
					end
				end
				S_FLUSH: begin
					if (step) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

// ----- src/ric_checker.sv -----
// Port-level checker for the relay interlock core, bound to the top level.
module ric_checker #(
	parameter int CHANNELS = 4
) (
	input logic                     clk,
	input logic                     arst_n,
	input logic                     in_valid,
	input logic                     in_ready,
	input logic                     mode,
	input logic [2:0]               channel,
	input logic                     out_valid,
	input logic                     out_ready,
	input logic [ric_pkg::CH_W-1:0] changed_channel,
	input logic                     new_state,
	input logic                     last
);
	import ric_pkg::*;

	localparam logic [2:0] CH_LIM = 3'(CHANNELS);

	// a stalled report holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(changed_channel)
			&& $stable(new_state) && $stable(last))
		else $error("report changed while stalled");

	// a tick or in-range command keeps the block busy for the next cycle
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && (mode || channel < CH_LIM) |=> !in_ready)
		else $error("ready after accepting a working item");

	// an out-of-range command is dropped and the block stays idle
	a_drop: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && !mode && !(channel < CH_LIM) |=> in_ready)
		else $error("out-of-range command started work");

	// a report never names a channel beyond the configured count
	a_ch_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> {1'b0, changed_channel} < CH_LIM)
		else $error("report on an absent channel");

endmodule

bind relay_interlock_inching_control_core ric_checker #(.CHANNELS(CHANNELS)) u_ric_checker (
	.clk             (clk),
	.arst_n          (arst_n),
	.in_valid        (in_valid),
	.in_ready        (in_ready),
	.mode            (mode),
	.channel         (channel),
	.out_valid       (out_valid),
	.out_ready       (out_ready),
	.changed_channel (changed_channel),
	.new_state       (new_state),
	.last            (last)
);
